/* src/antiflicker_exposure_split_core_assert.svh */
// ---------------------------------------------------------------------------
// antiflicker exposure split core assertion macros
// Shared concurrent assertion forms, clocked on clock, held off in reset.
// ---------------------------------------------------------------------------
`ifndef ANTIFLICKER_EXPOSURE_SPLIT_CORE_ASSERT_SVH
`define ANTIFLICKER_EXPOSURE_SPLIT_CORE_ASSERT_SVH

// same-cycle implication
`define AFES_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("afes assertion failed");

// next-cycle implication
`define AFES_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("afes assertion failed");

`endif

/* src/afes_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afes_pkg
// Types and constants of the antiflicker exposure split core.
// ---------------------------------------------------------------------------
package afes_pkg;

   localparam int NODE_DEPTH = 64;
   localparam int NODE_IDX_W = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
   localparam int NODE_CNT_W = $clog2(NODE_DEPTH + 1);
   localparam int NODE_W     = 16;
   localparam int NODES_W    = 7;
   localparam logic [NODE_W-1:0] NODE_LIMIT = 16'hffff;

   localparam int LINE_W = 20;
   localparam int GAIN_W = 20;
   localparam int EXP_W  = 40;
   localparam int STEP_W = 32;

   localparam int DIV_NUM_W = EXP_W + 1;
   localparam int DIV_DEN_W = STEP_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      CMD_BUILD = 1'b0,
      CMD_PLAN  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_MIN_LINES    = 3'd0,
      REG_MAX_LINES    = 3'd1,
      REG_MIN_GAIN     = 3'd2,
      REG_MAX_GAIN     = 3'd3,
      REG_FLOOR_LINES  = 3'd4,
      REG_STEP_NUM     = 3'd5,
      REG_STEP_DEN     = 3'd6,
      REG_NODES_ENABLE = 3'd7
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_B_DIV,
      ST_B_STEP,
      ST_P_LO,
      ST_P_HI,
      ST_P_CLAMP,
      ST_P_IDEAL,
      ST_P_DIV1,
      ST_P_RD,
      ST_P_CHK,
      ST_P_PICK,
      ST_P_GSTART,
      ST_P_DIV2
   } state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [EXP_W-1:0]   desired_exp;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [LINE_W-1:0]  lines_out;
      logic [GAIN_W-1:0]  gain_out;
      logic [NODES_W-1:0] nodes_used;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
      logic [DIV_DEN_W-1:0] remainder;
   } div_rsp_type;

endpackage

/* src/afes_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afes_div
// Restoring divider, one quotient bit per cycle, done strobe at the end.
// ---------------------------------------------------------------------------
module afes_div
   import afes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 run_ff;
   logic                 done_ff;

   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == DIV_CNT_W'(1));
         if (div_req.start) begin
            run_ff <= 1'b1;
            cnt_ff <= DIV_CNT_W'(DIV_NUM_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff <= div_req.dividend;
         rem_ff <= '0;
         dvs_ff <= div_req.divisor;
      end else if (run_ff) begin
         if (fits) begin
            rem_ff <= DIV_DEN_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_ff <= trial[DIV_DEN_W-1:0];
         end
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

/* src/antiflicker_exposure_split_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// antiflicker_exposure_split_core
// Anti-flicker node table builder and exposure to lines/gain planner.
// ---------------------------------------------------------------------------
// One request at a time: start is taken while busy is low, and the result is
// shown for a single cycle on rsp_data with rsp_valid high; the receiver
// cannot stall it. A build runs the step division in the shared bit-serial
// divider, then computes and stores the nodes in turn, at most NODE_DEPTH of
// them. A plan runs its two divisions and the clamps, with a read and a check
// of each table entry in use between them; the node table sits in a
// single-port memory with a registered read. A rejected configuration
// answers in the cycle after the request.
module antiflicker_exposure_split_core
   import afes_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // configuration
   logic [LINE_W-1:0] min_lines_ff, max_lines_ff, floor_ff;
   logic [GAIN_W-1:0] min_gain_ff, max_gain_ff;
   logic [STEP_W-1:0] num_ff, den_ff;
   logic              enable_ff;
   logic              csr_wr;
   csr_reg_type       csr_sel;

   state_type state_ff, state_in;

   cmd_type              cmd_ff;
   logic [EXP_W-1:0]     des_ff;
   logic [STEP_W-1:0]    sq_ff, sr_ff, r_ff;
   logic [STEP_W+1:0]    q_ff;
   logic [NODE_CNT_W-1:0] cnt_ff, total_ff, total_in, pcount_ff;
   logic [EXP_W-1:0]     lo_ff, hi_ff;
   logic [DIV_NUM_W-1:0] ideal_ff;
   logic [NODE_IDX_W-1:0] idx_ff;
   logic [NODE_W-1:0]    prev_ff, node0_ff, cand_ff, rd_data_ff;
   logic [LINE_W-1:0]    integ_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [NODE_W-1:0]    node_mem [NODE_DEPTH];

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                 accept;
   logic                 step_bad, cfg_bad;
   logic [STEP_W+1:0]    q_sum, nq;
   logic [STEP_W:0]      r_sum;
   logic                 r_wrap;
   logic [STEP_W-1:0]    nr;
   logic                 build_stop, build_full;
   logic                 chk_bad, last_node;
   logic [LINE_W-1:0]    mul_a;
   logic [GAIN_W-1:0]    mul_b;
   logic [EXP_W-1:0]     mul_p, des_clamp;
   logic [LINE_W-1:0]    pick0, pick1, pick2, pick3;
   logic [GAIN_W-1:0]    gain_clamp;
   logic                 mem_we, mem_re;
   logic [NODE_IDX_W-1:0] mem_addr;
   logic                 fin;
   status_type           fin_status;

   afes_div u_afes_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // configuration port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = csr_reg_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_lines_ff <= LINE_W'(1);
         max_lines_ff <= LINE_W'(65535);
         min_gain_ff  <= GAIN_W'(1024);
         max_gain_ff  <= GAIN_W'(65535);
         floor_ff     <= '0;
         num_ff       <= STEP_W'(1);
         den_ff       <= STEP_W'(1);
         enable_ff    <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_MIN_LINES:    min_lines_ff <= csr_pwdata[LINE_W-1:0];
            REG_MAX_LINES:    max_lines_ff <= csr_pwdata[LINE_W-1:0];
            REG_MIN_GAIN:     min_gain_ff  <= csr_pwdata[GAIN_W-1:0];
            REG_MAX_GAIN:     max_gain_ff  <= csr_pwdata[GAIN_W-1:0];
            REG_FLOOR_LINES:  floor_ff     <= csr_pwdata[LINE_W-1:0];
            REG_STEP_NUM:     num_ff       <= csr_pwdata[STEP_W-1:0];
            REG_STEP_DEN:     den_ff       <= csr_pwdata[STEP_W-1:0];
            REG_NODES_ENABLE: enable_ff    <= csr_pwdata[0];
            default:          enable_ff    <= enable_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_MIN_LINES:    csr_prdata = CSR_DATA_W'(min_lines_ff);
         REG_MAX_LINES:    csr_prdata = CSR_DATA_W'(max_lines_ff);
         REG_MIN_GAIN:     csr_prdata = CSR_DATA_W'(min_gain_ff);
         REG_MAX_GAIN:     csr_prdata = CSR_DATA_W'(max_gain_ff);
         REG_FLOOR_LINES:  csr_prdata = CSR_DATA_W'(floor_ff);
         REG_STEP_NUM:     csr_prdata = num_ff;
         REG_STEP_DEN:     csr_prdata = den_ff;
         REG_NODES_ENABLE: csr_prdata = CSR_DATA_W'(enable_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // datapath conditions
   always_comb begin
      accept   = start && (state_ff == ST_IDLE);
      step_bad = (den_ff == '0) || (num_ff < den_ff);
      cfg_bad  = (min_lines_ff == '0) || (min_lines_ff > max_lines_ff) ||
                 (min_gain_ff == '0) || (min_gain_ff > max_gain_ff) ||
                 (floor_ff > max_lines_ff);

      // next node: quotient and remainder advance by one step
      q_sum  = q_ff + {2'b00, sq_ff};
      r_sum  = {1'b0, r_ff} + {1'b0, sr_ff};
      r_wrap = r_sum >= {1'b0, den_ff};
      nq     = q_sum + (STEP_W + 2)'(r_wrap);
      nr     = r_wrap ? STEP_W'(r_sum - {1'b0, den_ff}) : r_sum[STEP_W-1:0];
      build_stop = (nq > (STEP_W + 2)'(max_lines_ff)) || (nq > (STEP_W + 2)'(NODE_LIMIT));
      build_full = cnt_ff == NODE_CNT_W'(NODE_DEPTH);

      chk_bad   = (rd_data_ff == '0) || ((idx_ff != '0) && (rd_data_ff <= prev_ff));
      last_node = (NODE_CNT_W'(idx_ff) + NODE_CNT_W'(1)) == pcount_ff;

      mul_a = (state_ff == ST_P_LO) ? min_lines_ff : max_lines_ff;
      mul_b = (state_ff == ST_P_LO) ? min_gain_ff : max_gain_ff;
      mul_p = mul_a * mul_b;

      if (des_ff < lo_ff) begin
         des_clamp = lo_ff;
      end else if (des_ff > hi_ff) begin
         des_clamp = hi_ff;
      end else begin
         des_clamp = des_ff;
      end

      // integration choice, then the final clamps
      if ((floor_ff != '0) && (ideal_ff < DIV_NUM_W'(floor_ff))) begin
         pick0 = floor_ff;
      end else if ((pcount_ff == '0) || (ideal_ff < DIV_NUM_W'(node0_ff))) begin
         if (ideal_ff < DIV_NUM_W'(min_lines_ff)) begin
            pick0 = min_lines_ff;
         end else if (ideal_ff > DIV_NUM_W'(max_lines_ff)) begin
            pick0 = max_lines_ff;
         end else begin
            pick0 = ideal_ff[LINE_W-1:0];
         end
      end else begin
         pick0 = LINE_W'(cand_ff);
      end
      pick1 = ((floor_ff != '0) && (pick0 < floor_ff)) ? floor_ff : pick0;
      pick2 = (pick1 < min_lines_ff) ? min_lines_ff : pick1;
      pick3 = (pick2 > max_lines_ff) ? max_lines_ff : pick2;

      if (div_rsp.quotient < DIV_NUM_W'(min_gain_ff)) begin
         gain_clamp = min_gain_ff;
      end else if (div_rsp.quotient > DIV_NUM_W'(max_gain_ff)) begin
         gain_clamp = max_gain_ff;
      end else begin
         gain_clamp = div_rsp.quotient[GAIN_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.cmd == CMD_BUILD) begin
                  state_in = step_bad ? ST_IDLE : ST_B_DIV;
               end else begin
                  state_in = cfg_bad ? ST_IDLE : ST_P_LO;
               end
            end
         end
         ST_B_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_B_STEP;
            end
         end
         ST_B_STEP: begin
            if (build_stop || build_full) begin
               state_in = ST_IDLE;
            end
         end
         ST_P_LO:    state_in = ST_P_HI;
         ST_P_HI:    state_in = ST_P_CLAMP;
         ST_P_CLAMP: state_in = ST_P_IDEAL;
         ST_P_IDEAL: state_in = ST_P_DIV1;
         ST_P_DIV1: begin
            if (div_rsp.done) begin
               state_in = ((enable_ff ? total_ff : '0) == '0) ? ST_P_PICK : ST_P_RD;
            end
         end
         ST_P_RD: state_in = ST_P_CHK;
         ST_P_CHK: begin
            if (chk_bad) begin
               state_in = ST_IDLE;
            end else if (last_node) begin
               state_in = ST_P_PICK;
            end else begin
               state_in = ST_P_RD;
            end
         end
         ST_P_PICK:   state_in = ST_P_GSTART;
         ST_P_GSTART: state_in = ST_P_DIV2;
         ST_P_DIV2: begin
            if (div_rsp.done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      div_req    = '0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = idx_ff;
      fin        = 1'b0;
      fin_status = STATUS_OK;
      total_in   = total_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.cmd == CMD_BUILD) begin
                  if (step_bad) begin
                     fin        = 1'b1;
                     fin_status = STATUS_INVALID;
                  end else begin
                     div_req.start    = 1'b1;
                     div_req.dividend = DIV_NUM_W'(num_ff);
                     div_req.divisor  = den_ff;
                  end
               end else if (cfg_bad) begin
                  fin        = 1'b1;
                  fin_status = STATUS_INVALID;
               end
            end
         end
         ST_B_STEP: begin
            mem_addr = cnt_ff[NODE_IDX_W-1:0];
            if (build_stop) begin
               fin      = 1'b1;
               total_in = cnt_ff;
            end else if (build_full) begin
               fin        = 1'b1;
               fin_status = STATUS_OVERFLOW;
               total_in   = '0;
            end else begin
               mem_we = 1'b1;
            end
         end
         ST_P_IDEAL: begin
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, des_ff} + DIV_NUM_W'(min_gain_ff >> 1);
            div_req.divisor  = DIV_DEN_W'(min_gain_ff);
         end
         ST_P_RD: mem_re = 1'b1;
         ST_P_CHK: begin
            if (chk_bad) begin
               fin        = 1'b1;
               fin_status = STATUS_INVALID;
            end
         end
         ST_P_GSTART: begin
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, des_ff} + DIV_NUM_W'(integ_ff >> 1);
            div_req.divisor  = DIV_DEN_W'(integ_ff);
         end
         ST_P_DIV2: fin = div_rsp.done;
         default: fin = 1'b0;
      endcase
   end

   // node table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_addr] <= nq[NODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= node_mem[mem_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= fin;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_data.cmd;
         des_ff <= req_data.desired_exp;
         cnt_ff <= '0;
      end
      if ((state_ff == ST_B_DIV) && div_rsp.done) begin
         sq_ff <= div_rsp.quotient[STEP_W-1:0];
         sr_ff <= div_rsp.remainder;
         q_ff  <= '0;
         r_ff  <= den_ff >> 1;
      end
      if (mem_we) begin
         q_ff   <= nq;
         r_ff   <= nr;
         cnt_ff <= cnt_ff + NODE_CNT_W'(1);
      end
      if (state_ff == ST_P_LO) begin
         lo_ff <= mul_p;
      end
      if (state_ff == ST_P_HI) begin
         hi_ff <= mul_p;
      end
      if (state_ff == ST_P_CLAMP) begin
         des_ff <= des_clamp;
      end
      if ((state_ff == ST_P_DIV1) && div_rsp.done) begin
         ideal_ff  <= div_rsp.quotient;
         idx_ff    <= '0;
         pcount_ff <= enable_ff ? total_ff : '0;
      end
      if (state_ff == ST_P_CHK) begin
         prev_ff <= rd_data_ff;
         idx_ff  <= idx_ff + NODE_IDX_W'(1);
         if (idx_ff == '0) begin
            node0_ff <= rd_data_ff;
            cand_ff  <= rd_data_ff;
         end else if ((DIV_NUM_W'(rd_data_ff) <= ideal_ff) &&
                      (LINE_W'(rd_data_ff) <= max_lines_ff)) begin
            cand_ff <= rd_data_ff;
         end
      end
      if (state_ff == ST_P_PICK) begin
         integ_ff <= pick3;
      end
      if (fin) begin
         rsp_ff.status     <= fin_status;
         rsp_ff.nodes_used <= NODES_W'(total_in);
         if ((state_ff == ST_P_DIV2) && (cmd_ff == CMD_PLAN)) begin
            rsp_ff.lines_out <= integ_ff;
            rsp_ff.gain_out  <= gain_clamp;
         end else begin
            rsp_ff.lines_out <= '0;
            rsp_ff.gain_out  <= '0;
         end
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/afes_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afes_assert_checker
// Port-level checks of the antiflicker exposure split core, bound to it.
// ---------------------------------------------------------------------------
`include "antiflicker_exposure_split_core_assert.svh"

module afes_assert_checker
   import afes_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   logic fail_rsp;

   assign fail_rsp = rsp_valid && (rsp_data.status != STATUS_OK);

   // a result only appears once the sequencer is back to idle
   `AFES_ASSERT_IMPL(a_rsp_idle, rsp_valid, !busy)
   // an accepted request either works or answers at once
   `AFES_ASSERT_NEXT(a_accept_progress, start && !busy, busy || rsp_valid)
   // failures carry no lines or gain
   `AFES_ASSERT_IMPL(a_fail_zero, fail_rsp, {rsp_data.lines_out, rsp_data.gain_out} == '0)

endmodule

bind antiflicker_exposure_split_core afes_assert_checker u_afes_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

/* bench/afes_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afes_checker
// Watches the request, result and register ports of the exposure split core.
// It keeps its own node table and register copies, works out the result of
// every accepted request and compares each result field by field.
// ---------------------------------------------------------------------------
module afes_checker
   import afes_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    fail_count,
   output int                    pending
);

   logic [NODE_W-1:0] shadow_nodes [NODE_DEPTH];
   int unsigned       shadow_total;
   int unsigned       min_lines, max_lines, min_gain, max_gain, floor_lines;
   int unsigned       step_num, step_den, nodes_en;
   rsp_type           expected_rsp [$];

   function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
      return (n + d / 2) / d;
   endfunction

   function automatic status_type build_table();
      int unsigned       count;
      longint unsigned   mult;
      longint unsigned   node;
      count = 0;
      if (step_den == 0 || step_num < step_den) return STATUS_INVALID;
      for (mult = 1; ; mult++) begin
         node = rdiv(longint'(step_num) * mult, step_den);
         if (node > max_lines || node > 64'hffff) break;
         if (count >= NODE_DEPTH) begin
            shadow_total = 0;
            return STATUS_OVERFLOW;
         end
         shadow_nodes[count] = node[NODE_W-1:0];
         count++;
      end
      shadow_total = count;
      return STATUS_OK;
   endfunction

   function automatic status_type plan_exposure(longint unsigned want,
                                               output int unsigned lines,
                                               output int unsigned gain);
      int unsigned     count, integ;
      longint unsigned lo, hi, ideal, g;
      lines = 0;
      gain = 0;
      count = nodes_en ? shadow_total : 0;
      if (min_lines == 0 || min_lines > max_lines || min_gain == 0 ||
          min_gain > max_gain || floor_lines > max_lines) return STATUS_INVALID;
      for (int i = 0; i < count; i++)
         if (shadow_nodes[i] == 0 || (i > 0 && shadow_nodes[i] <= shadow_nodes[i-1]))
            return STATUS_INVALID;
      lo = longint'(min_lines) * min_gain;
      hi = longint'(max_lines) * max_gain;
      if (want < lo) want = lo;
      if (want > hi) want = hi;
      ideal = rdiv(want, min_gain);
      if (floor_lines != 0 && ideal < floor_lines) begin
         integ = floor_lines;
      end else if (count == 0 || ideal < shadow_nodes[0]) begin
         if (ideal < min_lines) integ = min_lines;
         else if (ideal > max_lines) integ = max_lines;
         else integ = ideal[31:0];
      end else begin
         integ = 32'(shadow_nodes[0]);
         for (int i = 1; i < count; i++) begin
            if (shadow_nodes[i] > ideal || shadow_nodes[i] > max_lines) break;
            integ = 32'(shadow_nodes[i]);
         end
      end
      if (floor_lines != 0 && integ < floor_lines) integ = floor_lines;
      if (integ < min_lines) integ = min_lines;
      if (integ > max_lines) integ = max_lines;
      g = rdiv(want, integ);
      if (g < min_gain) g = min_gain;
      if (g > max_gain) g = max_gain;
      lines = integ;
      gain = g[31:0];
      return STATUS_OK;
   endfunction

   assign pending = expected_rsp.size();

   always @(posedge clock) begin
      rsp_type     exp_r, got;
      int unsigned l, g;
      if (reset) begin
         shadow_total = 0;
         min_lines = 1; max_lines = 65535; min_gain = 1024; max_gain = 65535;
         floor_lines = 0; step_num = 1; step_den = 1; nodes_en = 0;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         // results always belong to an earlier request, so they are checked first
         if (rsp_valid) begin
            got = rsp_data;
            if (expected_rsp.size() == 0) begin
               $error("result with no request waiting");
               fail_count++;
            end else begin
               exp_r = expected_rsp.pop_front();
               if (got.status !== exp_r.status) begin
                  $error("status expected %0d actual %0d", exp_r.status, got.status);
                  fail_count++;
               end
               if (got.lines_out !== exp_r.lines_out) begin
                  $error("lines_out expected %0d actual %0d", exp_r.lines_out,
                         got.lines_out);
                  fail_count++;
               end
               if (got.gain_out !== exp_r.gain_out) begin
                  $error("gain_out expected %0d actual %0d", exp_r.gain_out,
                         got.gain_out);
                  fail_count++;
               end
               if (got.nodes_used !== exp_r.nodes_used) begin
                  $error("nodes_used expected %0d actual %0d", exp_r.nodes_used,
                         got.nodes_used);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            l = 0;
            g = 0;
            if (req_data.cmd == CMD_BUILD) exp_r.status = build_table();
            else exp_r.status = plan_exposure(req_data.desired_exp, l, g);
            exp_r.lines_out  = l[LINE_W-1:0];
            exp_r.gain_out   = g[GAIN_W-1:0];
            exp_r.nodes_used = shadow_total[NODES_W-1:0];
            expected_rsp.push_back(exp_r);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_reg_type'(csr_paddr[4:2]))
               REG_MIN_LINES:    min_lines   = 32'(csr_pwdata[LINE_W-1:0]);
               REG_MAX_LINES:    max_lines   = 32'(csr_pwdata[LINE_W-1:0]);
               REG_MIN_GAIN:     min_gain    = 32'(csr_pwdata[GAIN_W-1:0]);
               REG_MAX_GAIN:     max_gain    = 32'(csr_pwdata[GAIN_W-1:0]);
               REG_FLOOR_LINES:  floor_lines = 32'(csr_pwdata[LINE_W-1:0]);
               REG_STEP_NUM:     step_num    = csr_pwdata;
               REG_STEP_DEN:     step_den    = csr_pwdata;
               REG_NODES_ENABLE: nodes_en    = 32'(csr_pwdata[0]);
               default: ;
            endcase
         end
      end
   end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives node table builds and exposure plans into the split core over a
// run of register settings, with and without request gaps; the checker
// beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top;
   import afes_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   int                    fail_count, pending;
   int                    cycles = 0;
   int                    gap_pct;

   antiflicker_exposure_split_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   afes_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic csr_write(csr_reg_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // keep start high across back-to-back requests, lower it only for gaps
   task automatic send(cmd_type cmd, logic [EXP_W-1:0] want);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_data <= '{cmd: cmd, desired_exp: want};
      start    <= 1'b1;
      @(negedge clock);
      while (busy) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [EXP_W-1:0] rand_exp();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(3))
         0: return raw[EXP_W-1:0];
         1: return raw[EXP_W-1:0] >> $urandom_range(39);
         2: return raw[27:0];
         default: return raw[23:0];
      endcase
   endfunction

   task automatic set_all(int unsigned mnl, int unsigned mxl, int unsigned mng,
                          int unsigned mxg, int unsigned fl, int unsigned num,
                          int unsigned den, int unsigned en);
      csr_write(REG_MIN_LINES, mnl);
      csr_write(REG_MAX_LINES, mxl);
      csr_write(REG_MIN_GAIN, mng);
      csr_write(REG_MAX_GAIN, mxg);
      csr_write(REG_FLOOR_LINES, fl);
      csr_write(REG_STEP_NUM, num);
      csr_write(REG_STEP_DEN, den);
      csr_write(REG_NODES_ENABLE, en);
   endtask

   initial begin
      int unsigned mnl, mxl, mng, mxg, fl, num, den;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      gap_pct     = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: unit step overflows the table
      send(CMD_PLAN, 40'd0);
      send(CMD_PLAN, '1);
      send(CMD_BUILD, 40'd0);
      drain();
      // zero denominator, then numerator below denominator
      csr_write(REG_STEP_DEN, 0);
      send(CMD_BUILD, '1);
      drain();
      csr_write(REG_STEP_NUM, 3);
      csr_write(REG_STEP_DEN, 7);
      send(CMD_BUILD, 40'd5);
      drain();
      // regular table, used and disabled
      set_all(8, 65535, 1024, 65535, 0, 10417, 10, 1);
      send(CMD_BUILD, 40'd0);
      send(CMD_PLAN, 40'd1);
      send(CMD_PLAN, 40'd500000);
      send(CMD_PLAN, 40'd5000000);
      send(CMD_PLAN, '1);
      drain();
      csr_write(REG_NODES_ENABLE, 0);
      send(CMD_PLAN, 40'd5000000);
      drain();
      // flicker floor and widest limits
      set_all(1, 1048575, 1, 1048575, 600, 32'hffffffff, 32'h10000, 1);
      send(CMD_BUILD, 40'd0);
      send(CMD_PLAN, 40'd300);
      send(CMD_PLAN, 40'd2000000);
      send(CMD_PLAN, '1);
      drain();
      // each invalid plan setting
      set_all(0, 65535, 1024, 65535, 0, 1, 1, 0);
      send(CMD_PLAN, 40'd1000);
      drain();
      set_all(100, 50, 1024, 65535, 0, 1, 1, 0);
      send(CMD_PLAN, 40'd1000);
      drain();
      set_all(1, 65535, 0, 65535, 0, 1, 1, 0);
      send(CMD_PLAN, 40'd1000);
      drain();
      set_all(1, 65535, 4000, 2000, 0, 1, 1, 0);
      send(CMD_PLAN, 40'd1000);
      drain();
      set_all(1, 500, 1024, 65535, 501, 1, 1, 0);
      send(CMD_PLAN, 40'd1000);
      drain();

      for (int phase = 0; phase < 16; phase++) begin
         case (phase % 4)
            0: gap_pct = 0;
            1: gap_pct = 72;
            2: gap_pct = 6;
            default: gap_pct = 0;
         endcase
         mnl = $urandom_range(1, 200);
         mxl = (phase % 5 == 0) ? 1048575 : $urandom_range(mnl, 70000);
         mng = $urandom_range(1, 4096);
         mxg = (phase % 6 == 0) ? 1048575 : $urandom_range(mng, 1048575);
         fl  = ($urandom_range(2) == 0) ? 0 : $urandom_range(0, mxl);
         den = $urandom_range(1, 1000);
         // aim at tables of up to 64 entries, sometimes a few more
         num = den * $urandom_range(((mxl > 65535 ? 65535 : mxl) / 70) + 1, 3000);
         if (phase == 7) begin
            num = $urandom;
            den = $urandom;
         end
         if (phase == 9) mnl = 0;
         set_all(mnl, mxl, mng, mxg, fl, num, den, $urandom_range(5) != 0);
         send(CMD_BUILD, rand_exp());
         for (int k = 0; k < 85; k++)
            send(($urandom_range(19) == 0) ? CMD_BUILD : CMD_PLAN, rand_exp());
         drain();
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
